// File: src/fce_pkg.sv
// Package for the cluster chain engine: table geometry, entry codes,
// command, status and register index codes, and the divider result struct. No dependencies.
`default_nettype none
package fce_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int TBL_AW = $clog2(TABLE_ENTRIES);

    localparam logic [31:0] FAT_EOC       = 32'h0FFF_FFFF;
    localparam logic [27:0] FAT_END_MIN   = 28'hFFF_FFF8;
    localparam logic [27:0] FIRST_CLUSTER = 28'd2;

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_LOOKUP = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_CHAIN_END = 2'd3;

    localparam logic [1:0] REG_DATA_CLUSTERS = 2'd0;
    localparam logic [1:0] REG_SECT_PER_CLUS = 2'd1;
    localparam logic [1:0] REG_FIRST_SECTOR  = 2'd2;

    typedef struct packed {
        logic        done;
        logic [19:0] quot;
        logic [7:0]  rem;
    } div_res_t;

endpackage
`default_nettype wire

// File: src/fce_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module fce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: src/fce_div.sv
// Restoring divider, one quotient bit per cycle, for block / sectors per cluster.
// Depends on fce_pkg for the result struct.
`default_nettype none
module fce_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [19:0]      dividend,
    input  wire logic [7:0]       divisor,
    output fce_pkg::div_res_t     res
);
    import fce_pkg::*;

    logic [19:0] q_reg, q_next;
    logic [7:0]  r_reg, r_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;
    logic        fits;

    assign trial = {r_reg, q_reg[19]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 5'd20;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[18:0], fits};
            r_next   = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;
    assign res.rem  = r_reg;

endmodule
`default_nettype wire

// File: src/fat_cluster_chain_engine_top.sv
// Top level of the cluster chain engine: command sequencer around the table RAM.
// Depends on fce_pkg, fce_ram and fce_div.
`default_nettype none
// After reset the engine zeroes every table entry and accepts no command until that
// pass ends. Each command then runs on a single-port table RAM with a registered
// read. A read addresses the entry, waits for the read data and responds; a write
// writes the entry and responds; a free writes a zero entry, first ending a previous
// cluster when one is given; any out-of-range rejection goes straight to the response.
// Allocate reads and checks each cluster of the upward scan, then links the previous
// cluster, if one is given, or reports a full volume. Block lookup runs a 20-bit
// serial divider for block / sectors per cluster, then follows the chain links and
// does a multiply and an add. A new command is taken once the previous one has
// placed its result in the output register, even if that beat is not yet taken.
module fat_cluster_chain_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [11:0] cluster,
    input  wire logic [11:0] prev_cluster,
    input  wire logic [31:0] entry_value,
    input  wire logic [19:0] block_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      value,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import fce_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_WT, S_LINK_WR, S_FREE_PREV,
        S_ENTRY_WR, S_READ_RD, S_READ_WT, S_DIV_GO, S_DIV, S_WALK_RD,
        S_WALK_WT, S_MUL, S_SUM, S_RESP
    } state_t;

    state_t         state_reg;
    logic [TBL_AW-1:0] clr_reg;
    logic [11:0]    dcc_reg;
    logic [7:0]     spc_reg;
    logic [31:0]    fds_reg;
    logic [11:0]    cl_reg, prev_reg, cur_reg;
    logic [31:0]    wr_data_reg;
    logic [12:0]    scan_reg;
    logic [19:0]    steps_reg, blk_reg;
    logic [7:0]     rem_reg;
    logic [19:0]    prod_reg;
    logic [31:0]    res_value_reg;
    logic [1:0]     res_status_reg;
    logic           out_valid_reg;
    logic [31:0]    value_reg;
    logic [1:0]     status_reg;

    logic              ram_we;
    logic [TBL_AW-1:0] ram_addr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic [7:0]        spc_eff;
    div_res_t          div_res;
    logic [27:0]       link;

    function automatic logic in_range(input logic [31:0] c, input logic [11:0] dcc);
        return (c >= 32'(FIRST_CLUSTER)) && (c <= 32'(dcc) + 32'd1) &&
               (c < 32'(TABLE_ENTRIES));
    endfunction

    assign spc_eff   = (spc_reg == 8'd0) ? 8'd1 : spc_reg;
    assign link      = ram_rdata[27:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    fce_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    fce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_GO),
        .dividend (blk_reg),
        .divisor  (spc_eff),
        .res      (div_res)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = TBL_AW'(cl_reg);
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            S_SCAN_RD:
                ram_addr = TBL_AW'(scan_reg);
            S_SCAN_WT:
            begin
                ram_we    = (link == 28'd0);
                ram_addr  = TBL_AW'(scan_reg);
                ram_wdata = FAT_EOC;
            end
            S_LINK_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = TBL_AW'(prev_reg);
                ram_wdata = 32'(scan_reg);
            end
            S_FREE_PREV:
            begin
                ram_we    = 1'b1;
                ram_addr  = TBL_AW'(prev_reg);
                ram_wdata = FAT_EOC;
            end
            S_ENTRY_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = wr_data_reg;
            end
            S_WALK_RD:
                ram_addr = TBL_AW'(cur_reg);
            default:
                ram_addr = TBL_AW'(cl_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            dcc_reg       <= 12'd4094;
            spc_reg       <= 8'd8;
            fds_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DATA_CLUSTERS: dcc_reg <= cfg_data[11:0];
                    REG_SECT_PER_CLUS: spc_reg <= cfg_data[7:0];
                    REG_FIRST_SECTOR:  fds_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && state_reg != S_RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == TBL_AW'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cl_reg         <= cluster;
                        prev_reg       <= prev_cluster;
                        cur_reg        <= cluster;
                        blk_reg        <= block_number;
                        res_value_reg  <= '0;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_RESP;
                        case (cmd)
                            CMD_ALLOC:
                            begin
                                if (prev_cluster != 12'd0 && !in_range(32'(prev_cluster), dcc_reg))
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    scan_reg  <= (prev_cluster == 12'd0) ? 13'd2
                                                 : 13'(prev_cluster) + 13'd1;
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            CMD_FREE:
                            begin
                                if (!in_range(32'(cluster), dcc_reg) ||
                                    (prev_cluster != 12'd0 &&
                                     !in_range(32'(prev_cluster), dcc_reg)))
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    wr_data_reg <= '0;
                                    state_reg   <= (prev_cluster != 12'd0) ? S_FREE_PREV
                                                   : S_ENTRY_WR;
                                end
                            end
                            CMD_READ:
                            begin
                                if (!in_range(32'(cluster), dcc_reg))
                                    res_status_reg <= ST_RANGE;
                                else
                                    state_reg <= S_READ_RD;
                            end
                            CMD_WRITE:
                            begin
                                if (!in_range(32'(cluster), dcc_reg))
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    wr_data_reg <= entry_value;
                                    state_reg   <= S_ENTRY_WR;
                                end
                            end
                            CMD_LOOKUP:
                            begin
                                if (!in_range(32'(cluster), dcc_reg))
                                    res_status_reg <= ST_RANGE;
                                else
                                    state_reg <= S_DIV_GO;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN_RD:
                begin
                    if (!in_range(32'(scan_reg), dcc_reg))
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_WT;
                    end
                end
                S_SCAN_WT:
                begin
                    if (link == 28'd0)
                    begin
                        res_value_reg <= 32'(scan_reg);
                        state_reg     <= (prev_reg != 12'd0) ? S_LINK_WR : S_RESP;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 13'd1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_LINK_WR:
                    state_reg <= S_RESP;
                S_FREE_PREV:
                    state_reg <= S_ENTRY_WR;
                S_ENTRY_WR:
                    state_reg <= S_RESP;
                S_READ_RD:
                    state_reg <= S_READ_WT;
                S_READ_WT:
                begin
                    res_value_reg <= ram_rdata;
                    state_reg     <= S_RESP;
                end
                S_DIV_GO:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        steps_reg <= div_res.quot;
                        rem_reg   <= div_res.rem;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_RD:
                    state_reg <= (steps_reg == 20'd0) ? S_MUL : S_WALK_WT;
                S_WALK_WT:
                begin
                    // A link below two or in the reserved top range ends the chain.
                    if (link < FIRST_CLUSTER || link >= FAT_END_MIN)
                    begin
                        res_status_reg <= ST_CHAIN_END;
                        state_reg      <= S_RESP;
                    end
                    else if (!in_range(32'(link), dcc_reg))
                    begin
                        res_status_reg <= ST_RANGE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        cur_reg   <= link[11:0];
                        steps_reg <= steps_reg - 20'd1;
                        state_reg <= S_WALK_RD;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 20'(cur_reg - 12'd2) * 20'(spc_eff);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    res_value_reg <= fds_reg + 32'(prod_reg) + 32'(rem_reg);
                    state_reg     <= S_RESP;
                end
                S_RESP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        value_reg     <= res_value_reg;
                        status_reg    <= res_status_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
